### design/sll_pkg.sv
// Shared constants, codes and helpers for the static linked list engine.
package sll_pkg;

    localparam int SLOTS      = 256;
    localparam int ELEM_WIDTH = 32;
    localparam int DATA_W     = 32;
    localparam int OP_W       = 3;
    localparam int POS_W      = 8;
    localparam int STAT_W     = 3;
    localparam int COUNT_W    = 8;

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CAPACITY  = SLOTS - 2;
    localparam int FREE_HEAD = 0;
    localparam int LIST_HEAD = SLOTS - 1;
    localparam int CMP_W     = ((SLOT_W > POS_W) ? SLOT_W : POS_W) + 1;

    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

    // Link held by a slot that has not been written since reset or clear
    function automatic logic [SLOT_W-1:0] reset_link(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] nxt;
        if (slot == SLOT_W'(SLOTS - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = slot + 1'b1;
        end
        return nxt;
    endfunction

endpackage

### design/sll_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/static_linked_list_engine.sv
// Top level of the static linked list engine: sequencer, link and data stores.
//
//  channel | direction | handshake            | word carries
//  --------+-----------+----------------------+--------------------------------------------
//  req     | in        | req_valid/req_stall  | operation, position, elem_x, elem_y
//  rsp     | out       | rsp_valid/rsp_stall  | status, found_position, out_x, out_y, list_count
//
// Requests: one word at a time. The link walk reads one slot per cycle through the
// link RAM read port; clear, bad position and the other early exits go from idle
// straight to the done state.
// Reset: rst_n clears the sequencer, the count and the per-slot link valid bits at
// once; an invalid slot reads as its reset link, so no clearing pass is needed.
// Stalls: a finished response waits in the done state while rsp_valid and rsp_stall are high.
module static_linked_list_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [sll_pkg::OP_W-1:0]            operation,
    input  logic [sll_pkg::POS_W-1:0]           position,
    input  logic signed [sll_pkg::DATA_W-1:0]   elem_x,
    input  logic signed [sll_pkg::DATA_W-1:0]   elem_y,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [sll_pkg::STAT_W-1:0]          status,
    output logic [sll_pkg::POS_W-1:0]           found_position,
    output logic signed [sll_pkg::DATA_W-1:0]   out_x,
    output logic signed [sll_pkg::DATA_W-1:0]   out_y,
    output logic [sll_pkg::COUNT_W-1:0]         list_count
);

    import sll_pkg::*;

    localparam int EW2 = 2 * ELEM_WIDTH;

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WALK   = 4'd1;
    localparam logic [3:0] S_LOC0   = 4'd2;
    localparam logic [3:0] S_LOC    = 4'd3;
    localparam logic [3:0] S_INS_F1 = 4'd4;
    localparam logic [3:0] S_INS_F2 = 4'd5;
    localparam logic [3:0] S_INS_W2 = 4'd6;
    localparam logic [3:0] S_DEL_R1 = 4'd7;
    localparam logic [3:0] S_DEL_R2 = 4'd8;
    localparam logic [3:0] S_DEL_W3 = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(LIST_HEAD);
    localparam logic [SLOT_W-1:0] FREE_SLOT = SLOT_W'(FREE_HEAD);

    // Control state
    logic [3:0]        state_reg, state_next;
    logic [SLOT_W-1:0] count_reg, count_next;
    logic [SLOTS-1:0]  link_vld_reg;
    logic              rsp_valid_reg, rsp_valid_next;

    // Working registers
    logic [OP_W-1:0]       op_reg, op_next;
    logic [ELEM_WIDTH-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [SLOT_W-1:0]     steps_reg, steps_next;
    logic [SLOT_W-1:0]     n_reg, n_next;
    logic [SLOT_W-1:0]     p_reg, p_next;
    logic [SLOT_W-1:0]     k_reg, k_next;
    logic [STAT_W-1:0]     stat_reg, stat_next;
    logic [POS_W-1:0]      fpos_reg, fpos_next;
    logic [DATA_W-1:0]     ox_reg, ox_next, oy_reg, oy_next;

    // Response register
    logic [STAT_W-1:0]  rsp_stat_reg;
    logic [POS_W-1:0]   rsp_fpos_reg;
    logic [DATA_W-1:0]  rsp_x_reg, rsp_y_reg;
    logic [COUNT_W-1:0] rsp_count_reg;
    logic               rsp_load;

    // Store ports
    logic [SLOT_W-1:0] rd_addr, rd_addr_q_reg;
    logic              link_vld_q_reg;
    logic [SLOT_W-1:0] link_q, link_rd;
    logic [EW2-1:0]    data_q;
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr, link_wdata;
    logic              data_we;
    logic              clr;

    // Position checks against the current count
    logic              is_empty, pos_zero, pos_over, pos_over_ins;
    logic [POS_W-1:0]  pos_less;

    sll_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_q)
    );

    sll_ram #(
        .WIDTH (EW2),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (p_reg),
        .wdata ({ey_reg, ex_reg}),
        .raddr (rd_addr),
        .rdata (data_q)
    );

    // A slot never written since reset or clear still holds its reset link
    assign link_rd = link_vld_q_reg ? link_q : reset_link(rd_addr_q_reg);

    assign is_empty     = (count_reg == '0);
    assign pos_zero     = (position == '0);
    assign pos_over     = CMP_W'(position) > CMP_W'(count_reg);
    assign pos_over_ins = CMP_W'(position) > (CMP_W'(count_reg) + 1'b1);
    assign pos_less     = position - 1'b1;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        cur_next    = cur_reg;
        steps_next  = steps_reg;
        n_next      = n_reg;
        p_next      = p_reg;
        k_next      = k_reg;
        stat_next   = stat_reg;
        fpos_next   = fpos_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        rd_addr     = rd_addr_q_reg;
        link_we     = 1'b0;
        link_waddr  = FREE_SLOT;
        link_wdata  = '0;
        data_we     = 1'b0;
        clr         = 1'b0;
        rsp_load    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = operation;
                    ex_next    = elem_x[ELEM_WIDTH-1:0];
                    ey_next    = elem_y[ELEM_WIDTH-1:0];
                    stat_next  = STAT_OK;
                    fpos_next  = '0;
                    ox_next    = '0;
                    oy_next    = '0;
                    state_next = S_DONE;
                    case (operation)
                        OP_GET:
                        begin
                            if (is_empty)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else if (pos_zero || pos_over)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                cur_next   = HEAD_SLOT;
                                steps_next = SLOT_W'(position);
                                rd_addr    = HEAD_SLOT;
                                state_next = S_WALK;
                            end
                        end
                        OP_LOCATE:
                        begin
                            if (is_empty)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = HEAD_SLOT;
                                state_next = S_LOC0;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (pos_zero || pos_over_ins)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else if (count_reg >= SLOT_W'(CAPACITY))
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                steps_next = SLOT_W'(pos_less);
                                rd_addr    = FREE_SLOT;
                                state_next = S_INS_F1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (is_empty)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else if (pos_zero || pos_over)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                cur_next   = HEAD_SLOT;
                                steps_next = SLOT_W'(pos_less);
                                rd_addr    = HEAD_SLOT;
                                state_next = S_WALK;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            clr        = 1'b1;
                        end
                        default:
                        begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end

            // Follow one link per cycle; the read of cur_reg was issued last cycle
            S_WALK:
            begin
                if (steps_reg != '0)
                begin
                    cur_next   = link_rd;
                    steps_next = steps_reg - 1'b1;
                    rd_addr    = link_rd;
                end
                else
                begin
                    state_next = S_DONE;
                    case (op_reg)
                        OP_GET:
                        begin
                            ox_next = DATA_W'(signed'(data_q[ELEM_WIDTH-1:0]));
                            oy_next = DATA_W'(signed'(data_q[EW2-1:ELEM_WIDTH]));
                        end
                        OP_INSERT:
                        begin
                            // new slot takes over the successor of the slot before it
                            link_we    = 1'b1;
                            link_waddr = p_reg;
                            link_wdata = link_rd;
                            data_we    = 1'b1;
                            k_next     = cur_reg;
                            state_next = S_INS_W2;
                        end
                        OP_DELETE:
                        begin
                            if (link_rd == '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                p_next     = link_rd;
                                k_next     = cur_reg;
                                rd_addr    = link_rd;
                                state_next = S_DEL_R1;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_LOC0:
            begin
                cur_next   = link_rd;
                n_next     = SLOT_W'(1);
                rd_addr    = link_rd;
                state_next = S_LOC;
            end

            // Stop at the chain end, else compare the slot read last cycle or advance
            S_LOC:
            begin
                if ((cur_reg == '0) || (CMP_W'(n_reg) > CMP_W'(count_reg)))
                begin
                    stat_next  = STAT_NOTFOUND;
                    state_next = S_DONE;
                end
                else if ((data_q[ELEM_WIDTH-1:0] == ex_reg) &&
                         (data_q[EW2-1:ELEM_WIDTH] == ey_reg))
                begin
                    fpos_next  = POS_W'(n_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next = link_rd;
                    n_next   = n_reg + 1'b1;
                    rd_addr  = link_rd;
                end
            end

            S_INS_F1:
            begin
                if (link_rd == '0)
                begin
                    stat_next  = STAT_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    p_next     = link_rd;
                    rd_addr    = link_rd;
                    state_next = S_INS_F2;
                end
            end

            // Pop the free slot, then walk to the slot before the position
            S_INS_F2:
            begin
                link_we    = 1'b1;
                link_waddr = FREE_SLOT;
                link_wdata = link_rd;
                cur_next   = HEAD_SLOT;
                rd_addr    = HEAD_SLOT;
                state_next = S_WALK;
            end

            S_INS_W2:
            begin
                link_we    = 1'b1;
                link_waddr = k_reg;
                link_wdata = p_reg;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end

            // Unlink the slot and push it on the free chain
            S_DEL_R1:
            begin
                ox_next    = DATA_W'(signed'(data_q[ELEM_WIDTH-1:0]));
                oy_next    = DATA_W'(signed'(data_q[EW2-1:ELEM_WIDTH]));
                link_we    = 1'b1;
                link_waddr = k_reg;
                link_wdata = link_rd;
                rd_addr    = FREE_SLOT;
                state_next = S_DEL_R2;
            end

            S_DEL_R2:
            begin
                link_we    = 1'b1;
                link_waddr = p_reg;
                link_wdata = link_rd;
                state_next = S_DEL_W3;
            end

            S_DEL_W3:
            begin
                link_we    = 1'b1;
                link_waddr = FREE_SLOT;
                link_wdata = p_reg;
                count_next = count_reg - 1'b1;
                state_next = S_DONE;
            end

            // Hold the result until the response register is free
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            link_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (clr)
            begin
                link_vld_reg <= '0;
            end
            else if (link_we)
            begin
                link_vld_reg[link_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        ex_reg         <= ex_next;
        ey_reg         <= ey_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        n_reg          <= n_next;
        p_reg          <= p_next;
        k_reg          <= k_next;
        stat_reg       <= stat_next;
        fpos_reg       <= fpos_next;
        ox_reg         <= ox_next;
        oy_reg         <= oy_next;
        rd_addr_q_reg  <= rd_addr;
        link_vld_q_reg <= link_vld_reg[rd_addr];
        if (rsp_load)
        begin
            rsp_stat_reg  <= stat_reg;
            rsp_fpos_reg  <= fpos_reg;
            rsp_x_reg     <= ox_reg;
            rsp_y_reg     <= oy_reg;
            rsp_count_reg <= COUNT_W'(count_reg);
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_stat_reg;
    assign found_position = rsp_fpos_reg;
    assign out_x          = rsp_x_reg;
    assign out_y          = rsp_y_reg;
    assign list_count     = rsp_count_reg;

    // An accepted word always starts the sequencer
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("accepted word left the sequencer idle");

    // The list never grows past its usable capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOT_W'(CAPACITY))
        else $error("element count above capacity");

    // A response appears only after the done state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside the done state");

endmodule
